// ----- src/alpsc_pkg.sv -----
// shared types, constants and helpers of the length-prefix to start-code converter
package alpsc_pkg;

    // sample handling mode
    typedef enum logic [3:0] {
        MODE_DECIDING = 4'b0001,
        MODE_PASS     = 4'b0010,
        MODE_CONVERT  = 4'b0100,
        MODE_IDLE     = 4'b1000
    } t_mode;

    // kind of queued output operation
    typedef enum logic {
        OP_BYTE  = 1'b0,
        OP_START = 1'b1
    } t_op_kind;

    // one queued operation: a single byte or a whole start code
    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] data;
        logic       start;
        logic       last;
    } t_op;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    localparam int unsigned Q_DEPTH         = 4;
    localparam int unsigned Q_PTR_BITS      = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_BITS      = $clog2(Q_DEPTH + 1);

    localparam int unsigned HELD_DEPTH      = 4;
    localparam int unsigned HELD_PTR_BITS   = $clog2(HELD_DEPTH);
    localparam int unsigned HELD_CNT_BITS   = $clog2(HELD_DEPTH + 1);

    localparam int unsigned SIZE_FIELD_BITS = 24;
    localparam int unsigned LEN_CFG_BITS    = 3;
    localparam int unsigned ACCUM_BITS      = 32;

    localparam logic [LEN_CFG_BITS-1:0] LEN_BYTES_RESET = 3'd4;
    localparam logic [LEN_CFG_BITS-1:0] LEN_BYTES_MIN   = 3'd1;
    localparam logic [LEN_CFG_BITS-1:0] LEN_BYTES_MAX   = 3'd4;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [7:0] BYTE_FF   = 8'hff;

    // effective prefix length, out-of-range settings clamped
    function automatic logic [LEN_CFG_BITS-1:0] prefix_len(input logic [LEN_CFG_BITS-1:0] cfg);
        logic [LEN_CFG_BITS-1:0] n;
        n = cfg;
        if (cfg < LEN_BYTES_MIN) n = LEN_BYTES_MIN;
        if (cfg > LEN_BYTES_MAX) n = LEN_BYTES_MAX;
        return n;
    endfunction

    // bytes of the start code 00 00 00 01
    function automatic logic [7:0] start_code_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd3:    b = BYTE_ONE;
            default: b = BYTE_ZERO;
        endcase
        return b;
    endfunction

endpackage

// ----- src/alpsc_in_if.sv -----
// input byte channel of the converter
interface alpsc_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        sample_first;
    logic        sample_last;
    logic [23:0] sample_size;

    modport source(output valid, data_byte, sample_first, sample_last, sample_size,
                   input ready);
    modport sink(input valid, data_byte, sample_first, sample_last, sample_size,
                 output ready);
endinterface

// ----- src/alpsc_out_if.sv -----
// output byte channel of the converter
interface alpsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       unit_start;
    logic       run_last;

    modport source(output valid, out_byte, unit_start, run_last, input ready);
    modport sink(input valid, out_byte, unit_start, run_last, output ready);
endinterface

// ----- src/avc_length_prefix_to_start_code_core.sv -----
// top level of the length-prefix to start-code converter
// a result byte passes through the pending-operation register, an operation queue entry and the output register
// throughput: one input byte per cycle while a finished operation can leave into the queue; the byte that completes
//   a sample's first four bytes (or ends a shorter sample) holds input low during the replay of the held bytes
// a start code is emitted as four output bytes; the four-entry operation queue absorbs the burst
// reset: synchronous active low; clears all control state, setting returns to four-byte prefixes
module avc_length_prefix_to_start_code_core import alpsc_pkg::*; #(
    parameter int unsigned SAMPLE_SIZE_BITS = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [LEN_CFG_BITS-1:0] i_cfg_wr_data,
    alpsc_in_if.sink                i_in,
    alpsc_out_if.source             o_out
);

    logic [LEN_CFG_BITS-1:0] r_len_bytes;
    logic                    q_push;
    t_op                     q_push_op;
    logic                    q_pop;
    t_op                     q_head;
    t_q_stat                 q_stat;

    // prefix length setting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_bytes <= LEN_BYTES_RESET;
        end else if (i_cfg_wr_en) begin
            r_len_bytes <= i_cfg_wr_data;
        end
    end

    // byte intake and parsing
    alpsc_front #(
        .SAMPLE_SIZE_BITS(SAMPLE_SIZE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_len_bytes (r_len_bytes),
        .i_q_stat    (q_stat),
        .o_push      (q_push),
        .o_push_op   (q_push_op)
    );

    // operation queue
    alpsc_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (q_push),
        .i_push_op (q_push_op),
        .i_pop     (q_pop),
        .o_head    (q_head),
        .o_stat    (q_stat)
    );

    // output expansion
    alpsc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_head   (q_head),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

    // queue never written when full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("operation pushed into a full queue");

    // queue never read when empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("operation popped from an empty queue");

    // reset leaves no result pending
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

endmodule

// ----- src/alpsc_queue.sv -----
// small operation queue between the front and the back
module alpsc_queue import alpsc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_op     i_push_op,
    input  logic    i_pop,
    output t_op     o_head,
    output t_q_stat o_stat
);

    t_op                   r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wp;
    logic [Q_PTR_BITS-1:0] r_rp;
    logic [Q_CNT_BITS-1:0] r_cnt;

    // status and head
    assign o_stat.full  = (r_cnt == Q_CNT_BITS'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + Q_PTR_BITS'(1);
            if (i_pop)  r_rp <= r_rp + Q_PTR_BITS'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + Q_CNT_BITS'(1);
                2'b01:   r_cnt <= r_cnt - Q_CNT_BITS'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_push_op;
    end

endmodule

// ----- src/alpsc_front.sv -----
// front: accepts sample bytes, decides the sample form and parses length prefixes
module alpsc_front import alpsc_pkg::*; #(
    parameter int unsigned SAMPLE_SIZE_BITS = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    alpsc_in_if.sink                i_in,
    input  logic [LEN_CFG_BITS-1:0] i_len_bytes,
    input  t_q_stat                 i_q_stat,
    output logic                    o_push,
    output t_op                     o_push_op
);

    localparam int unsigned SSB      = SAMPLE_SIZE_BITS;
    localparam int unsigned EXT_BITS = (SSB > SIZE_FIELD_BITS) ? SSB : SIZE_FIELD_BITS;
    localparam int unsigned SUM_BITS = ((SSB > ACCUM_BITS) ? SSB : ACCUM_BITS) + 2;

    // state
    logic [7:0]               r_held [HELD_DEPTH];
    logic [7:0]               n_held [HELD_DEPTH];
    logic [HELD_CNT_BITS-1:0] r_hcnt, n_hcnt;
    t_mode                    r_mode, n_mode;
    logic                     r_ncy, n_ncy;
    logic [ACCUM_BITS-1:0]    r_accum, n_accum;
    logic [LEN_CFG_BITS-1:0]  r_lbs, n_lbs;
    logic [ACCUM_BITS-1:0]    r_pleft, n_pleft;
    logic [SSB-1:0]           r_pos, n_pos;
    logic [SSB-1:0]           r_total, n_total;
    logic                     r_replay, n_replay;
    logic [HELD_PTR_BITS-1:0] r_ridx, n_ridx;
    logic [HELD_CNT_BITS-1:0] r_rcnt, n_rcnt;
    logic                     r_rend, n_rend;
    t_op                      r_pend, n_pend;
    logic                     r_pend_v, n_pend_v;

    // working signals
    logic                    adv;
    logic                    step_end;
    logic                    set_idle;
    logic                    op_v;
    t_op                     op;
    logic                    conv_en;
    logic [7:0]              conv_b;
    logic [SSB-1:0]          conv_pos;
    logic [SSB-1:0]          cur_pos;
    logic [SSB:0]            pos_inc;
    logic                    ends;
    logic                    is_pass;
    logic [ACCUM_BITS-1:0]   acc;
    logic [LEN_CFG_BITS-1:0] lbs_inc;
    logic [SUM_BITS-1:0]     unit_end;
    logic [LEN_CFG_BITS-1:0] plen;
    logic [EXT_BITS-1:0]     size_ext;
    logic [SSB-1:0]          in_size;

    assign plen     = prefix_len(i_len_bytes);
    assign size_ext = EXT_BITS'(i_in.sample_size);
    assign in_size  = size_ext[SSB-1:0];

    // input taken only outside a replay and when a finished operation can leave
    assign i_in.ready = !r_replay && (!r_pend_v || !i_q_stat.full);
    assign adv        = (r_replay || i_in.valid) && (!r_pend_v || !i_q_stat.full);

    always_comb begin
        n_held   = r_held;
        n_hcnt   = r_hcnt;
        n_mode   = r_mode;
        n_ncy    = r_ncy;
        n_accum  = r_accum;
        n_lbs    = r_lbs;
        n_pleft  = r_pleft;
        n_pos    = r_pos;
        n_total  = r_total;
        n_replay = r_replay;
        n_ridx   = r_ridx;
        n_rcnt   = r_rcnt;
        n_rend   = r_rend;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        step_end = 1'b0;
        set_idle = 1'b0;
        op_v     = 1'b0;
        op       = '{kind: OP_BYTE, data: BYTE_ZERO, start: 1'b0, last: 1'b0};
        conv_en  = 1'b0;
        conv_b   = BYTE_ZERO;
        conv_pos = '0;
        cur_pos  = '0;
        pos_inc  = '0;
        ends     = 1'b0;
        is_pass  = 1'b0;
        acc      = '0;
        lbs_inc  = '0;
        unit_end = '0;

        if (adv) begin
            if (r_replay) begin
                // replay of the held bytes after the decision
                if (r_mode == MODE_PASS) begin
                    op_v     = 1'b1;
                    op.data  = r_held[r_ridx];
                    op.start = (r_ridx == '0);
                end else if (r_mode == MODE_CONVERT) begin
                    conv_en  = 1'b1;
                    conv_b   = r_held[r_ridx];
                    conv_pos = SSB'(r_ridx);
                end
                if (HELD_CNT_BITS'(r_ridx) + HELD_CNT_BITS'(1) == r_rcnt) begin
                    n_replay = 1'b0;
                    step_end = 1'b1;
                    set_idle = r_rend;
                end else begin
                    n_ridx = r_ridx + HELD_PTR_BITS'(1);
                end
            end else begin
                step_end = 1'b1;
                // new sample restarts the per-sample state
                if (i_in.sample_first) begin
                    n_total = in_size;
                    n_pos   = '0;
                    n_hcnt  = '0;
                    n_mode  = MODE_DECIDING;
                    n_accum = '0;
                    n_lbs   = '0;
                    n_pleft = '0;
                end
                if (n_mode != MODE_IDLE) begin
                    if (n_pos >= n_total) begin
                        n_mode = MODE_IDLE;
                    end else begin
                        cur_pos = n_pos;
                        n_pos   = cur_pos + SSB'(1);
                        pos_inc = (SSB + 1)'(cur_pos) + (SSB + 1)'(1);
                        ends    = i_in.sample_last || (pos_inc >= (SSB + 1)'(n_total));
                        case (n_mode)
                            MODE_DECIDING: begin
                                if (n_hcnt < HELD_CNT_BITS'(HELD_DEPTH)) begin
                                    n_held[n_hcnt[HELD_PTR_BITS-1:0]] = i_in.data_byte;
                                end
                                n_hcnt = n_hcnt + HELD_CNT_BITS'(1);
                                if (n_hcnt >= HELD_CNT_BITS'(HELD_DEPTH) || ends) begin
                                    // pattern check on the bytes held so far
                                    is_pass =
                                        (n_hcnt > 3'd3 && n_held[0] == BYTE_ZERO
                                         && n_held[1] == BYTE_ZERO && n_held[2] == BYTE_ZERO
                                         && n_held[3] == BYTE_ONE)
                                        || (n_hcnt > 3'd2 && r_ncy && n_held[0] == BYTE_ZERO
                                         && n_held[1] == BYTE_ZERO && n_held[2] == BYTE_ONE)
                                        || (n_hcnt > 3'd3 && n_held[0] == BYTE_FF
                                         && n_held[1] == BYTE_FF && n_held[2] == BYTE_FF
                                         && n_held[3] == BYTE_FF);
                                    if (is_pass) begin
                                        n_mode = MODE_PASS;
                                    end else begin
                                        n_mode = MODE_CONVERT;
                                        n_ncy  = 1'b0;
                                    end
                                    n_replay = 1'b1;
                                    n_ridx   = '0;
                                    n_rcnt   = n_hcnt;
                                    n_rend   = ends;
                                    step_end = 1'b0;
                                end
                            end
                            MODE_PASS: begin
                                op_v    = 1'b1;
                                op.data = i_in.data_byte;
                            end
                            MODE_CONVERT: begin
                                conv_en  = 1'b1;
                                conv_b   = i_in.data_byte;
                                conv_pos = cur_pos;
                            end
                            default: ;
                        endcase
                        set_idle = ends && !n_replay;
                    end
                end
            end

            // shared prefix parser and payload copy
            if (conv_en) begin
                if (n_pleft != '0) begin
                    op_v    = 1'b1;
                    op.data = conv_b;
                    n_pleft = n_pleft - ACCUM_BITS'(1);
                end else begin
                    acc     = {n_accum[ACCUM_BITS-9:0], conv_b};
                    lbs_inc = n_lbs + LEN_CFG_BITS'(1);
                    if (lbs_inc < plen) begin
                        n_accum = acc;
                        n_lbs   = lbs_inc;
                    end else begin
                        n_accum = '0;
                        n_lbs   = '0;
                        if (acc != '0) begin
                            unit_end = SUM_BITS'(conv_pos) + SUM_BITS'(1) + SUM_BITS'(acc);
                            if (unit_end > SUM_BITS'(n_total)) begin
                                n_mode = MODE_IDLE;
                            end else begin
                                op_v     = 1'b1;
                                op.kind  = OP_START;
                                op.start = 1'b1;
                                n_pleft  = acc;
                            end
                        end
                    end
                end
            end

            if (set_idle) n_mode = MODE_IDLE;
        end

        // one-deep hold so the last operation of a request can be marked
        if (adv && op_v) begin
            n_pend      = op;
            n_pend.last = step_end;
            n_pend_v    = 1'b1;
        end else if (r_pend_v && !i_q_stat.full && r_pend.last) begin
            n_pend_v = 1'b0;
        end else if (adv && step_end && r_pend_v) begin
            n_pend.last = 1'b1;
        end
    end

    assign o_push    = r_pend_v && !i_q_stat.full && (r_pend.last || (adv && op_v));
    assign o_push_op = r_pend;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt   <= '0;
            r_mode   <= MODE_DECIDING;
            r_ncy    <= 1'b1;
            r_accum  <= '0;
            r_lbs    <= '0;
            r_pleft  <= '0;
            r_pos    <= '0;
            r_total  <= '0;
            r_replay <= 1'b0;
            r_ridx   <= '0;
            r_rcnt   <= '0;
            r_rend   <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_hcnt   <= n_hcnt;
            r_mode   <= n_mode;
            r_ncy    <= n_ncy;
            r_accum  <= n_accum;
            r_lbs    <= n_lbs;
            r_pleft  <= n_pleft;
            r_pos    <= n_pos;
            r_total  <= n_total;
            r_replay <= n_replay;
            r_ridx   <= n_ridx;
            r_rcnt   <= n_rcnt;
            r_rend   <= n_rend;
            r_pend_v <= n_pend_v;
        end
    end

    // held bytes and pending operation
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        r_pend <= n_pend;
    end

endmodule

// ----- src/alpsc_back.sv -----
// back: expands queued operations into output bytes behind an output register
module alpsc_back import alpsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_stat     i_q_stat,
    input  t_op         i_head,
    output logic        o_pop,
    alpsc_out_if.source o_out
);

    logic       r_ov;
    logic [7:0] r_ob;
    logic       r_us;
    logic       r_rl;
    logic [1:0] r_sub;

    logic       load;
    logic [7:0] b_byte;
    logic       b_us;
    logic       b_rl;
    logic       b_done;

    assign load = !i_q_stat.empty && (!r_ov || o_out.ready);

    // byte selection for the head operation
    always_comb begin
        case (i_head.kind)
            OP_START: begin
                b_byte = start_code_byte(r_sub);
                b_us   = (r_sub == 2'd0);
                b_rl   = i_head.last && (r_sub == 2'd3);
                b_done = (r_sub == 2'd3);
            end
            default: begin
                b_byte = i_head.data;
                b_us   = i_head.start;
                b_rl   = i_head.last;
                b_done = 1'b1;
            end
        endcase
    end

    assign o_pop = load && b_done;

    // output valid and start code position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_sub <= 2'd0;
        end else if (load) begin
            r_ov <= 1'b1;
            if (i_head.kind == OP_START) r_sub <= r_sub + 2'd1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ob <= b_byte;
            r_us <= b_us;
            r_rl <= b_rl;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_byte   = r_ob;
    assign o_out.unit_start = r_us;
    assign o_out.run_last   = r_rl;

endmodule

// ----- tb/alpsc_stream_checker.sv -----
`timescale 1ns / 100ps
// stream checker: predicts the start-code output of the converter and compares it
module alpsc_stream_checker import alpsc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [LEN_CFG_BITS-1:0] i_cfg_wr_data,
    alpsc_in_if                     i_in_mon,
    alpsc_out_if                    i_out_mon,
    output int unsigned             o_fail_count,
    output int unsigned             o_pending
);

    localparam int unsigned MAX_PER_BYTE = 12;

    typedef struct packed {
        logic [7:0] data;
        logic       unit_start;
        logic       run_last;
    } t_stream_byte;

    // bytes still owed by the block, oldest first
    t_stream_byte expected_stream[$];
    // bytes caused by the request being predicted
    t_stream_byte step_bytes[$];

    logic [LEN_CFG_BITS-1:0]    len_setting;
    logic [7:0]                 head_bytes[HELD_DEPTH];
    int unsigned                head_count;
    t_mode                      mode;
    bit                         none_converted;
    logic [ACCUM_BITS-1:0]      len_accum;
    int unsigned                len_bytes_seen;
    logic [ACCUM_BITS-1:0]      payload_left;
    logic [SIZE_FIELD_BITS-1:0] byte_pos;
    logic [SIZE_FIELD_BITS-1:0] sample_bytes;
    int unsigned                fail_count;

    // bytes per length prefix, settings outside 1..4 clamped
    function automatic int unsigned prefix_bytes();
        if (len_setting == 0) return 1;
        if (len_setting > 4) return 4;
        return 32'(len_setting);
    endfunction

    function automatic bit head_is(input int unsigned idx, input logic [7:0] v);
        return idx < head_count && head_bytes[idx] == v;
    endfunction

    task automatic push_byte(input logic [7:0] d, input bit start);
        t_stream_byte sb;
        sb.data       = d;
        sb.unit_start = start;
        sb.run_last   = 1'b0;
        if (step_bytes.size() < MAX_PER_BYTE) step_bytes.push_back(sb);
    endtask

    // one byte of a converted sample: prefix collection or payload copy
    task automatic convert_byte(input logic [7:0] b, input logic [SIZE_FIELD_BITS-1:0] pos);
        logic [ACCUM_BITS-1:0] nal_len;
        if (payload_left != 0) begin
            push_byte(b, 1'b0);
            payload_left = payload_left - 1;
            return;
        end
        len_accum = {len_accum[ACCUM_BITS-9:0], b};
        len_bytes_seen++;
        if (len_bytes_seen < prefix_bytes()) return;
        nal_len        = len_accum;
        len_accum      = '0;
        len_bytes_seen = 0;
        if (nal_len == 0) return;
        // unit would run past the sample: drop the rest
        if (64'(pos) + 64'(nal_len) + 64'd1 > 64'(sample_bytes)) begin
            mode = MODE_IDLE;
            return;
        end
        for (int i = 0; i < 4; i++) push_byte(i == 3 ? BYTE_ONE : BYTE_ZERO, i == 0);
        payload_left = nal_len;
    endtask

    // choose pass-through or conversion from the held head bytes
    task automatic decide_sample();
        bit pass;
        pass = (head_is(0, BYTE_ZERO) && head_is(1, BYTE_ZERO) && head_is(2, BYTE_ZERO)
                && head_is(3, BYTE_ONE))
            || (head_is(0, BYTE_ZERO) && head_is(1, BYTE_ZERO) && head_is(2, BYTE_ONE)
                && none_converted)
            || (head_is(0, BYTE_FF) && head_is(1, BYTE_FF) && head_is(2, BYTE_FF)
                && head_is(3, BYTE_FF));
        if (pass) begin
            mode = MODE_PASS;
            for (int i = 0; i < head_count; i++) push_byte(head_bytes[i], i == 0);
            return;
        end
        none_converted = 1'b0;
        mode = MODE_CONVERT;
        for (int i = 0; i < head_count; i++) begin
            if (mode != MODE_CONVERT) break;
            convert_byte(head_bytes[i], SIZE_FIELD_BITS'(i));
        end
    endtask

    // expected output bytes of one accepted request
    task automatic predict_request(input logic [7:0] b, input bit first, input bit last,
                                   input logic [SIZE_FIELD_BITS-1:0] size);
        logic [SIZE_FIELD_BITS-1:0] pos;
        bit ends;
        t_stream_byte tail;
        step_bytes.delete();
        if (first) begin
            sample_bytes   = size;
            byte_pos       = '0;
            head_count     = 0;
            mode           = MODE_DECIDING;
            len_accum      = '0;
            len_bytes_seen = 0;
            payload_left   = '0;
        end
        if (mode == MODE_IDLE) return;
        if (byte_pos >= sample_bytes) begin
            mode = MODE_IDLE;
            return;
        end
        pos      = byte_pos;
        byte_pos = byte_pos + 1'b1;
        ends     = last || (32'(pos) + 32'd1 >= 32'(sample_bytes));
        case (mode)
            MODE_DECIDING: begin
                if (head_count < HELD_DEPTH) head_bytes[head_count] = b;
                head_count++;
                if (head_count >= HELD_DEPTH || ends) decide_sample();
            end
            MODE_PASS: begin
                push_byte(b, 1'b0);
            end
            default: begin
                convert_byte(b, pos);
            end
        endcase
        if (ends) mode = MODE_IDLE;
        if (step_bytes.size() > 0) begin
            tail = step_bytes.pop_back();
            tail.run_last = 1'b1;
            step_bytes.push_back(tail);
        end
        foreach (step_bytes[i]) expected_stream.push_back(step_bytes[i]);
    endtask

    // predict on accepted requests, compare on accepted results
    always @(posedge i_clk) begin
        t_stream_byte got;
        t_stream_byte want;
        if (!i_rst_n) begin
            len_setting    = LEN_BYTES_RESET;
            head_count     = 0;
            mode           = MODE_DECIDING;
            none_converted = 1'b1;
            len_accum      = '0;
            len_bytes_seen = 0;
            payload_left   = '0;
            byte_pos       = '0;
            sample_bytes   = '0;
            fail_count     = 0;
            expected_stream.delete();
            for (int i = 0; i < HELD_DEPTH; i++) head_bytes[i] = '0;
        end else begin
            if (i_cfg_wr_en) len_setting = i_cfg_wr_data;
            if (i_in_mon.valid && i_in_mon.ready) begin
                predict_request(i_in_mon.data_byte, i_in_mon.sample_first,
                                i_in_mon.sample_last, i_in_mon.sample_size);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.data       = i_out_mon.out_byte;
                got.unit_start = i_out_mon.unit_start;
                got.run_last   = i_out_mon.run_last;
                if (expected_stream.size() == 0) begin
                    $display("%0t: expected no result byte, actual %02h start %b last %b",
                             $time, got.data, got.unit_start, got.run_last);
                    fail_count++;
                end else begin
                    want = expected_stream.pop_front();
                    if (got != want) begin
                        if (got.data != want.data)
                            $display("%0t: out_byte expected %02h actual %02h",
                                     $time, want.data, got.data);
                        if (got.unit_start != want.unit_start)
                            $display("%0t: unit_start expected %b actual %b",
                                     $time, want.unit_start, got.unit_start);
                        if (got.run_last != want.run_last)
                            $display("%0t: run_last expected %b actual %b",
                                     $time, want.run_last, got.run_last);
                        fail_count++;
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_stream.size();
    end

endmodule

// ----- tb/tb_avc_length_prefix_to_start_code_core.sv -----
`timescale 1ns / 100ps
// top of the converter testbench: clock, reset, sample stimulus and verdict
module tb_avc_length_prefix_to_start_code_core;
    import alpsc_pkg::*;

    localparam int unsigned RANDOM_BYTES = 280;
    localparam int unsigned LONG_HOLD    = 400;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [LEN_CFG_BITS-1:0] cfg_wr_data;
    int unsigned             fail_count;
    int unsigned             pending;
    bit                      stalls_on;
    bit                      long_hold_req;
    int unsigned             bytes_sent;
    logic [7:0]              sample_q[$];

    alpsc_in_if  in_ch();
    alpsc_out_if out_ch();

    avc_length_prefix_to_start_code_core dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in         (in_ch),
        .o_out        (out_ch)
    );

    alpsc_stream_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // run limit
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        forever begin
            if (long_hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end else if (stalls_on && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    function automatic int unsigned prefix_bytes(input logic [LEN_CFG_BITS-1:0] v);
        if (v == 0) return 1;
        if (v > 4) return 4;
        return 32'(v);
    endfunction

    // one request, held until the block takes it
    task automatic send_byte(input logic [7:0] b, input bit first, input bit last,
                             input logic [23:0] size);
        if (stalls_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= b;
        in_ch.sample_first <= first;
        in_ch.sample_last  <= last;
        in_ch.sample_size  <= size;
        do @(posedge clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    // bytes of sample_q as one sample; size only matters on the first byte
    task automatic send_sample(input logic [23:0] size, input bit mark_last);
        for (int i = 0; i < sample_q.size(); i++)
            send_byte(sample_q[i], i == 0, mark_last && i == sample_q.size() - 1,
                      i == 0 ? size : 24'($urandom));
    endtask

    // wait until every expected result is out, then let the pipeline empty
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_len_setting(input logic [LEN_CFG_BITS-1:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // length-prefixed units with random content, some with zero length or running past the sample
    task automatic build_converted(input int unsigned plen);
        logic [31:0] mask;
        logic [31:0] lv;
        int unsigned n;
        mask = (plen >= 4) ? 32'hffff_ffff : (32'd1 << (8 * plen)) - 1;
        sample_q.delete();
        repeat ($urandom_range(1, 3)) begin
            n = $urandom_range(0, 7);
            case ($urandom_range(0, 9))
                0: begin
                    lv = 0;
                    n  = 0;
                end
                1: begin
                    // length running past the sample
                    lv = 32'($urandom) & mask;
                    if (lv <= 32) lv = mask;
                end
                default: lv = n;
            endcase
            for (int k = plen; k > 0; k--) sample_q.push_back(8'(lv >> (8 * (k - 1))));
            repeat (n) sample_q.push_back(8'($urandom));
        end
    endtask

    task automatic random_sample(input int unsigned plen);
        int unsigned kind;
        int unsigned full;
        logic [7:0] pick;
        kind = $urandom_range(0, 19);
        if (kind < 12) begin
            build_converted(plen);
            full = sample_q.size();
            case ($urandom_range(0, 5))
                0: send_sample(24'(full + $urandom_range(1, 20)), 1'b1);
                1: send_sample(24'($urandom_range(1, full)), 1'($urandom_range(0, 1)));
                2: begin
                    // left open, abandoned by the next sample start
                    repeat ($urandom_range(1, full)) void'(sample_q.pop_back());
                    send_sample(24'(full), 1'b0);
                end
                3: send_sample(24'hffffff, 1'b1);
                default: send_sample(24'(full), 1'($urandom_range(0, 1)));
            endcase
        end else if (kind < 14) begin
            // start-code headers
            case ($urandom_range(0, 2))
                0: sample_q = '{8'h00, 8'h00, 8'h00, 8'h01};
                1: sample_q = '{8'hff, 8'hff, 8'hff, 8'hff};
                default: sample_q = '{8'h00, 8'h00, 8'h01};
            endcase
            repeat ($urandom_range(0, 8)) sample_q.push_back(8'($urandom));
            send_sample(24'(sample_q.size()), 1'($urandom_range(0, 1)));
        end else if (kind < 16) begin
            // samples shorter than the head
            sample_q.delete();
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 3))
                    0: pick = 8'h00;
                    1: pick = 8'h01;
                    2: pick = 8'hff;
                    default: pick = 8'($urandom);
                endcase
                sample_q.push_back(pick);
            end
            send_sample(24'(sample_q.size()), 1'($urandom_range(0, 1)));
        end else begin
            // loose bytes with random framing
            repeat ($urandom_range(1, 10))
                send_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0,
                          $urandom_range(0, 1) ? 24'($urandom_range(0, 12)) : 24'($urandom));
        end
    endtask

    // stimulus
    initial begin
        logic [LEN_CFG_BITS-1:0] sweep[8];
        logic [LEN_CFG_BITS-1:0] setting;
        int unsigned phase;
        sweep = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd5, 3'd6, 3'd7};
        stalls_on     = 1'b1;
        long_hold_req = 1'b0;
        bytes_sent    = 0;
        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.data_byte    <= '0;
        in_ch.sample_first <= 1'b0;
        in_ch.sample_last  <= 1'b0;
        in_ch.sample_size  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: stray byte before any sample
        send_byte(8'h5a, 1'b0, 1'b0, 24'hffffff);
        // three-byte start code before any conversion passes through
        sample_q = '{8'h00, 8'h00, 8'h01, 8'haa};
        send_sample(24'd4, 1'b1);
        // zero length then a one-byte unit, ended by size
        sample_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h7f};
        send_sample(24'd9, 1'b0);
        // four-byte start code passes through
        sample_q = '{8'h00, 8'h00, 8'h00, 8'h01};
        send_sample(24'd4, 1'b1);
        // all-ones head passes through, largest size
        sample_q = '{8'hff, 8'hff, 8'hff, 8'hff, 8'h80};
        send_sample(24'hffffff, 1'b1);
        // zero sample size
        sample_q = '{8'h33};
        send_sample(24'd0, 1'b0);
        // sample ending inside its first prefix
        sample_q = '{8'h00, 8'h00};
        send_sample(24'd2, 1'b1);
        // one-byte prefixes: two units inside the head
        write_len_setting(3'd1);
        sample_q = '{8'h01, 8'h7e, 8'h01, 8'h7f};
        send_sample(24'd4, 1'b1);

        // random samples over a sweep of prefix settings
        bytes_sent = 0;
        phase = 0;
        while (bytes_sent < RANDOM_BYTES || phase < 8) begin
            setting = (phase < 8) ? sweep[phase] : 3'($urandom_range(0, 7));
            write_len_setting(setting);
            stalls_on = (phase % 3 != 2);
            if (phase == 2) long_hold_req = 1'b1;
            repeat (4) random_sample(prefix_bytes(setting));
            phase++;
        end

        // closing stretch without any idling
        stalls_on = 1'b0;
        write_len_setting(3'd4);
        repeat (4) random_sample(4);

        settle();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
